### hw/rtl/grid_flood_fill_3d_assert.svh
// Assertion macros shared by the flood fill RTL.
`ifndef GRID_FLOOD_FILL_3D_ASSERT_SVH
`define GRID_FLOOD_FILL_3D_ASSERT_SVH

// Condition that must hold at every clock edge outside reset.
`define GFF_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Same-cycle implication.
`define GFF_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define GFF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/gff3_pkg.sv
// Package: types, codes and constants of the 3D flood fill block.
`default_nettype none

package gff3_pkg;

    localparam int GFF_DIM_BITS    = 5;
    localparam int GFF_QUEUE_DEPTH = 32768;
    localparam int GFF_SIZE_W      = 6;
    localparam int GFF_COORD_W     = 5;
    localparam int GFF_CFG_IDX_W   = 2;

    localparam logic [GFF_SIZE_W-1:0] GFF_SIZE_RESET = 6'd32;

    // Configuration register indexes
    localparam logic [GFF_CFG_IDX_W-1:0] REG_SIZE_X = 2'd0;
    localparam logic [GFF_CFG_IDX_W-1:0] REG_SIZE_Y = 2'd1;
    localparam logic [GFF_CFG_IDX_W-1:0] REG_SIZE_Z = 2'd2;

    // Commands
    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_FILL  = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;
    localparam logic [1:0] CMD_NOP   = 2'd3;

    // Cell classes
    localparam logic [1:0] CLS_OPEN    = 2'd0;
    localparam logic [1:0] CLS_REACHED = 2'd1;
    localparam logic [1:0] CLS_BLOCKED = 2'd2;

    // Result status codes
    localparam logic [1:0] STS_DONE         = 2'd0;
    localparam logic [1:0] STS_SEED_BLOCKED = 2'd1;
    localparam logic [1:0] STS_SEED_REACHED = 2'd2;
    localparam logic [1:0] STS_OUTSIDE      = 2'd3;

    typedef struct packed {
        logic [1:0]             command;
        logic [GFF_COORD_W-1:0] cell_x;
        logic [GFF_COORD_W-1:0] cell_y;
        logic [GFF_COORD_W-1:0] cell_z;
        logic [1:0]             cell_class;
    } in_item_t;

    typedef struct packed {
        logic [1:0] status;
        logic [1:0] cell_value;
    } res_item_t;

    // Neighbour directions, visited in this order
    typedef enum logic [2:0] {
        DIR_XM,
        DIR_XP,
        DIR_YM,
        DIR_YP,
        DIR_ZM,
        DIR_ZP
    } dir_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOK,
        S_EVAL,
        S_POP,
        S_POPW,
        S_NRD,
        S_NCHK,
        S_DONE
    } state_t;

endpackage

`default_nettype wire

### hw/rtl/gff3_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
`default_nettype none

module gff3_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### hw/rtl/gff3_nbr.sv
// Shared neighbour unit: one step along one axis plus the bounds compare.
`default_nettype none

module gff3_nbr import gff3_pkg::*; #(
    parameter int DIM_BITS = GFF_DIM_BITS
) (
    input  wire logic [DIM_BITS-1:0]   cur_x,
    input  wire logic [DIM_BITS-1:0]   cur_y,
    input  wire logic [DIM_BITS-1:0]   cur_z,
    input  wire logic [DIM_BITS:0]     ext_x,
    input  wire logic [DIM_BITS:0]     ext_y,
    input  wire logic [DIM_BITS:0]     ext_z,
    input  wire dir_t                  dir,
    output logic      [3*DIM_BITS-1:0] nbr_idx,
    output logic                       nbr_ok
);

    logic [DIM_BITS-1:0] coord;
    logic [DIM_BITS:0]   ext;
    logic                down;
    logic                valid_dir;
    logic [DIM_BITS:0]   sum;
    logic [DIM_BITS-1:0] nx;
    logic [DIM_BITS-1:0] ny;
    logic [DIM_BITS-1:0] nz;

    // Axis select
    always_comb
    begin
        coord     = cur_x;
        ext       = ext_x;
        down      = 1'b0;
        valid_dir = 1'b1;
        case (dir)
            DIR_XM:
            begin
                coord = cur_x;
                ext   = ext_x;
                down  = 1'b1;
            end
            DIR_XP:
            begin
                coord = cur_x;
                ext   = ext_x;
            end
            DIR_YM:
            begin
                coord = cur_y;
                ext   = ext_y;
                down  = 1'b1;
            end
            DIR_YP:
            begin
                coord = cur_y;
                ext   = ext_y;
            end
            DIR_ZM:
            begin
                coord = cur_z;
                ext   = ext_z;
                down  = 1'b1;
            end
            DIR_ZP:
            begin
                coord = cur_z;
                ext   = ext_z;
            end
            default:
            begin
                valid_dir = 1'b0;
            end
        endcase
    end

    // One adder: +1 or -1 (add all ones), then the bound check
    assign sum = {1'b0, coord} + (down ? {1'b0, {DIM_BITS{1'b1}}} : (DIM_BITS+1)'(1));

    always_comb
    begin
        if (!valid_dir)
        begin
            nbr_ok = 1'b0;
        end
        else if (down)
        begin
            nbr_ok = (coord != '0);
        end
        else
        begin
            nbr_ok = (sum < ext);
        end
    end

    // Put the stepped coordinate back into the cell index
    always_comb
    begin
        nx = cur_x;
        ny = cur_y;
        nz = cur_z;
        case (dir)
            DIR_XM, DIR_XP: nx = sum[DIM_BITS-1:0];
            DIR_YM, DIR_YP: ny = sum[DIM_BITS-1:0];
            DIR_ZM, DIR_ZP: nz = sum[DIM_BITS-1:0];
            default:        nx = cur_x;
        endcase
    end

    assign nbr_idx = {nz, ny, nx};

endmodule

`default_nettype wire

### hw/rtl/grid_flood_fill_3d.sv
// Top level of the 3D six-connected breadth-first flood fill block.
//
// Holds a grid of 2^(3*DIM_BITS) two-bit cells (open, reached, blocked) in one RAM and
// a FIFO of cell indexes in a second RAM. After reset the block first clears the cell
// RAM, one cell per cycle, through all 2^(3*DIM_BITS) cells (32768 at the default); in_ready
// stays low during that pass, configuration writes are taken throughout. A write, read,
// rejected fill or out-of-range command passes through the LOOK, EVAL and DONE states;
// its result beat is loaded into the output register from DONE once that register is free.
// A fill steps through POP and POPW for every cell it dequeues, then NRD and NCHK for
// each in-bounds neighbour and NRD alone for each clipped one, until the queue is empty.
// Its speed is set by the single read port of the cell RAM, which serves one
// neighbour lookup at a time, and by the one shared neighbour step unit. The block takes
// one command at a time; a finished result waits in the output register without holding
// up the next accept.
`default_nettype none
`include "grid_flood_fill_3d_assert.svh"

module grid_flood_fill_3d import gff3_pkg::*; #(
    parameter int DIM_BITS    = GFF_DIM_BITS,
    parameter int QUEUE_DEPTH = GFF_QUEUE_DEPTH
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_write,
    input  wire logic [GFF_CFG_IDX_W-1:0] cfg_index,
    input  wire logic [GFF_SIZE_W-1:0]    cfg_data,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire in_item_t                 in_data,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output res_item_t                     out_data
);

    localparam int IDX_W = 3 * DIM_BITS;
    localparam int CELLS = 1 << IDX_W;
    localparam int EDGE  = 1 << DIM_BITS;
    localparam int EW    = DIM_BITS + 1;
    localparam int CMP_W = (EW > GFF_SIZE_W) ? EW : GFF_SIZE_W;
    localparam int QA_W  = $clog2(QUEUE_DEPTH);
    localparam int QC_W  = $clog2(QUEUE_DEPTH + 1);

    // Registers
    state_t                state_reg, state_next;
    logic [GFF_SIZE_W-1:0] size_x_reg, size_y_reg, size_z_reg;
    logic [IDX_W-1:0]      clr_cnt_reg, clr_cnt_next;
    in_item_t              item_reg, item_next;
    res_item_t             res_reg, res_next;
    logic                  out_valid_reg, out_valid_next;
    res_item_t             out_data_reg, out_data_next;
    logic [DIM_BITS-1:0]   cur_x_reg, cur_x_next;
    logic [DIM_BITS-1:0]   cur_y_reg, cur_y_next;
    logic [DIM_BITS-1:0]   cur_z_reg, cur_z_next;
    dir_t                  dir_reg, dir_next;
    logic [QA_W-1:0]       head_reg, head_next;
    logic [QA_W-1:0]       tail_reg, tail_next;
    logic [QC_W-1:0]       count_reg, count_next;

    // RAM ports
    logic             cell_we;
    logic [IDX_W-1:0] cell_waddr;
    logic [1:0]       cell_wdata;
    logic [IDX_W-1:0] cell_raddr;
    logic [1:0]       cell_rdata;
    logic             q_we;
    logic [QA_W-1:0]  q_waddr;
    logic [IDX_W-1:0] q_wdata;
    logic [QA_W-1:0]  q_raddr;
    logic [IDX_W-1:0] q_rdata;

    // Misc combinational
    logic [CMP_W-1:0]    ext_x, ext_y, ext_z;
    logic                outside;
    logic [DIM_BITS-1:0] seed_x, seed_y, seed_z;
    logic [IDX_W-1:0]    item_idx;
    logic [IDX_W-1:0]    nbr_idx;
    logic                nbr_ok;
    logic                can_push;
    logic                push;
    logic                seed_start;
    logic                accept;
    logic                out_free;
    logic [1:0]          class_sat;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_x_reg <= GFF_SIZE_RESET;
            size_y_reg <= GFF_SIZE_RESET;
            size_z_reg <= GFF_SIZE_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_SIZE_X: size_x_reg <= cfg_data;
                REG_SIZE_Y: size_y_reg <= cfg_data;
                REG_SIZE_Z: size_z_reg <= cfg_data;
                default:    size_x_reg <= size_x_reg;
            endcase
        end
    end

    // Extents capped at the grid edge
    assign ext_x = (CMP_W'(size_x_reg) > CMP_W'(EDGE)) ? CMP_W'(EDGE) : CMP_W'(size_x_reg);
    assign ext_y = (CMP_W'(size_y_reg) > CMP_W'(EDGE)) ? CMP_W'(EDGE) : CMP_W'(size_y_reg);
    assign ext_z = (CMP_W'(size_z_reg) > CMP_W'(EDGE)) ? CMP_W'(EDGE) : CMP_W'(size_z_reg);

    assign outside = (CMP_W'(item_reg.cell_x) >= ext_x) ||
                     (CMP_W'(item_reg.cell_y) >= ext_y) ||
                     (CMP_W'(item_reg.cell_z) >= ext_z);

    assign seed_x   = DIM_BITS'(item_reg.cell_x);
    assign seed_y   = DIM_BITS'(item_reg.cell_y);
    assign seed_z   = DIM_BITS'(item_reg.cell_z);
    assign item_idx = {seed_z, seed_y, seed_x};

    assign class_sat = (item_reg.cell_class > CLS_BLOCKED) ? CLS_BLOCKED : item_reg.cell_class;

    assign accept     = in_valid && in_ready;
    assign out_free   = !out_valid_reg || out_ready;
    assign can_push   = (count_reg < QC_W'(QUEUE_DEPTH));
    assign push       = (state_reg == S_NCHK) && (cell_rdata == CLS_OPEN) && can_push;
    assign seed_start = (state_reg == S_EVAL) && (item_reg.command == CMD_FILL) &&
                        !outside && (cell_rdata == CLS_OPEN);

    // Shared neighbour step unit
    gff3_nbr #(
        .DIM_BITS (DIM_BITS)
    ) u_nbr (
        .cur_x   (cur_x_reg),
        .cur_y   (cur_y_reg),
        .cur_z   (cur_z_reg),
        .ext_x   (EW'(ext_x)),
        .ext_y   (EW'(ext_y)),
        .ext_z   (EW'(ext_z)),
        .dir     (dir_reg),
        .nbr_idx (nbr_idx),
        .nbr_ok  (nbr_ok)
    );

    // Cell class store
    gff3_ram #(
        .WIDTH (2),
        .DEPTH (CELLS)
    ) u_cell_ram (
        .clk   (clk),
        .we    (cell_we),
        .waddr (cell_waddr),
        .wdata (cell_wdata),
        .raddr (cell_raddr),
        .rdata (cell_rdata)
    );

    // Pending cell FIFO
    gff3_ram #(
        .WIDTH (IDX_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue_ram (
        .clk   (clk),
        .we    (q_we),
        .waddr (q_waddr),
        .wdata (q_wdata),
        .raddr (q_raddr),
        .rdata (q_rdata)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (clr_cnt_reg == {IDX_W{1'b1}})
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                state_next = seed_start ? S_POP : S_DONE;
            end
            S_POP:
            begin
                state_next = (count_reg == '0) ? S_DONE : S_POPW;
            end
            S_POPW:
            begin
                state_next = S_NRD;
            end
            S_NRD:
            begin
                if (nbr_ok)
                begin
                    state_next = S_NCHK;
                end
                else if (dir_reg == DIR_ZP)
                begin
                    state_next = S_POP;
                end
            end
            S_NCHK:
            begin
                state_next = (dir_reg == DIR_ZP) ? S_POP : S_NRD;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Handshake and RAM controls
    always_comb
    begin
        in_ready   = 1'b0;
        cell_we    = 1'b0;
        cell_waddr = item_idx;
        cell_wdata = CLS_REACHED;
        cell_raddr = item_idx;
        q_we       = 1'b0;
        q_waddr    = tail_reg;
        q_wdata    = nbr_idx;
        q_raddr    = head_reg;
        case (state_reg)
            S_CLEAR:
            begin
                cell_we    = 1'b1;
                cell_waddr = clr_cnt_reg;
                cell_wdata = CLS_OPEN;
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
            end
            S_EVAL:
            begin
                if (!outside && item_reg.command == CMD_WRITE)
                begin
                    cell_we    = 1'b1;
                    cell_wdata = class_sat;
                end
                else if (seed_start)
                begin
                    cell_we = 1'b1;
                    q_we    = 1'b1;
                    q_waddr = '0;
                    q_wdata = item_idx;
                end
            end
            S_NRD:
            begin
                cell_raddr = nbr_idx;
            end
            S_NCHK:
            begin
                cell_waddr = nbr_idx;
                cell_we    = push;
                q_we       = push;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // Datapath next values
    always_comb
    begin
        clr_cnt_next   = clr_cnt_reg;
        item_next      = item_reg;
        res_next       = res_reg;
        cur_x_next     = cur_x_reg;
        cur_y_next     = cur_y_reg;
        cur_z_next     = cur_z_reg;
        dir_next       = dir_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;
        if (accept)
        begin
            item_next = in_data;
        end
        case (state_reg)
            S_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
            end
            S_EVAL:
            begin
                res_next.status     = STS_DONE;
                res_next.cell_value = CLS_OPEN;
                if (item_reg.command == CMD_NOP)
                begin
                    res_next.status = STS_DONE;
                end
                else if (outside)
                begin
                    res_next.status = STS_OUTSIDE;
                end
                else if (item_reg.command == CMD_READ)
                begin
                    res_next.cell_value = cell_rdata;
                end
                else if (item_reg.command == CMD_FILL)
                begin
                    if (cell_rdata == CLS_BLOCKED)
                    begin
                        res_next.status = STS_SEED_BLOCKED;
                    end
                    else if (cell_rdata == CLS_REACHED)
                    begin
                        res_next.status = STS_SEED_REACHED;
                    end
                end
                if (seed_start)
                begin
                    head_next  = '0;
                    tail_next  = QA_W'(1);
                    count_next = QC_W'(1);
                end
            end
            S_POP:
            begin
                if (count_reg != '0)
                begin
                    head_next  = (head_reg == QA_W'(QUEUE_DEPTH - 1)) ? '0 : head_reg + 1'b1;
                    count_next = count_reg - 1'b1;
                end
            end
            S_POPW:
            begin
                cur_x_next = q_rdata[DIM_BITS-1:0];
                cur_y_next = q_rdata[2*DIM_BITS-1:DIM_BITS];
                cur_z_next = q_rdata[3*DIM_BITS-1:2*DIM_BITS];
                dir_next   = DIR_XM;
            end
            S_NRD:
            begin
                if (!nbr_ok && dir_reg != DIR_ZP)
                begin
                    dir_next = dir_t'(dir_reg + 3'd1);
                end
            end
            S_NCHK:
            begin
                if (push)
                begin
                    tail_next  = (tail_reg == QA_W'(QUEUE_DEPTH - 1)) ? '0 : tail_reg + 1'b1;
                    count_next = count_reg + 1'b1;
                end
                if (dir_reg != DIR_ZP)
                begin
                    dir_next = dir_t'(dir_reg + 3'd1);
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = res_reg;
                end
            end
            default:
            begin
                dir_next = dir_reg;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        res_reg      <= res_next;
        cur_x_reg    <= cur_x_next;
        cur_y_reg    <= cur_y_next;
        cur_z_reg    <= cur_z_next;
        dir_reg      <= dir_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Checks
    `GFF_ASSERT_ALWAYS(a_count_bound, count_reg <= QC_W'(QUEUE_DEPTH), "queue count overflow")
    `GFF_ASSERT_IMP(a_idle_empty, state_reg == S_IDLE, count_reg == '0, "queue not drained")
    `GFF_ASSERT_IMP(a_empty_ptrs, count_reg == '0, head_reg == tail_reg, "empty queue, head != tail")
    `GFF_ASSERT_NEXT(a_push_count, push, count_reg == QC_W'($past(count_reg) + 1'b1), "count not bumped")

endmodule

`default_nettype wire

### tb/sv/grid_flood_fill_3d_tb.sv
// Testbench for the 3D flood fill block: directed and random command streams.
`timescale 1ns / 100ps

module grid_flood_fill_3d_tb;
    import gff3_pkg::*;

    localparam int EDGE          = 1 << GFF_DIM_BITS;
    localparam int CELLS         = 1 << (3 * GFF_DIM_BITS);
    localparam int LIMIT_CYCLES  = 1_000_000;
    localparam int SETTLE_CYCLES = 16;

    logic                     clk       = 1'b0;
    logic                     rst_n     = 1'b0;
    logic                     cfg_write = 1'b0;
    logic [GFF_CFG_IDX_W-1:0] cfg_index = REG_SIZE_X;
    logic [GFF_SIZE_W-1:0]    cfg_data  = '0;
    logic                     in_valid  = 1'b0;
    logic                     in_ready;
    in_item_t                 in_data   = '0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    res_item_t                out_data;

    // Shadow copy of the grid and the active extents
    logic [1:0] shadow_cells [CELLS];
    int         ext_x;
    int         ext_y;
    int         ext_z;
    res_item_t  awaited_results [$];
    res_item_t  want;

    int errors;
    int results_checked;
    int cmds_sent;
    int fills_sent;
    int settings_used;
    int cycle_count;
    int stall_left;
    bit idling = 1'b1;

    grid_flood_fill_3d dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always #6 clk = ~clk;

    function automatic int cell_at(input int x, input int y, input int z);
        return x | (y << GFF_DIM_BITS) | (z << (2 * GFF_DIM_BITS));
    endfunction

    // Breadth-first marking of every open cell connected to the seed
    function automatic void flood_from(input int sx, input int sy, input int sz);
        int   frontier [$];
        int   idx;
        int   x;
        int   y;
        int   z;
        int   nx;
        int   ny;
        int   nz;
        int   n;
        dir_t dir;
        shadow_cells[cell_at(sx, sy, sz)] = CLS_REACHED;
        frontier.insert(frontier.size(), cell_at(sx, sy, sz));
        while (frontier.size() > 0)
        begin
            idx = frontier.pop_front();
            x = idx % EDGE;
            y = (idx / EDGE) % EDGE;
            z = idx / (EDGE * EDGE);
            for (int d = 0; d < 6; d++)
            begin
                dir = dir_t'(d);
                nx = x;
                ny = y;
                nz = z;
                case (dir)
                    DIR_XM: nx = x - 1;
                    DIR_XP: nx = x + 1;
                    DIR_YM: ny = y - 1;
                    DIR_YP: ny = y + 1;
                    DIR_ZM: nz = z - 1;
                    default: nz = z + 1;
                endcase
                if (nx >= 0 && nx < ext_x && ny >= 0 && ny < ext_y && nz >= 0 && nz < ext_z)
                begin
                    n = cell_at(nx, ny, nz);
                    if (shadow_cells[n] == CLS_OPEN)
                    begin
                        shadow_cells[n] = CLS_REACHED;
                        frontier.insert(frontier.size(), n);
                    end
                end
            end
        end
    endfunction

    // Updates the shadow grid for one command and returns its result
    function automatic res_item_t apply_command(input in_item_t item);
        res_item_t res;
        int        idx;
        res.status     = STS_DONE;
        res.cell_value = CLS_OPEN;
        idx = cell_at(item.cell_x, item.cell_y, item.cell_z);
        if (item.command == CMD_NOP)
            return res;
        if (item.cell_x >= ext_x || item.cell_y >= ext_y || item.cell_z >= ext_z)
        begin
            res.status = STS_OUTSIDE;
            return res;
        end
        case (item.command)
            CMD_WRITE:
            begin
                if (item.cell_class == CLS_OPEN || item.cell_class == CLS_REACHED)
                    shadow_cells[idx] = item.cell_class;
                else
                    shadow_cells[idx] = CLS_BLOCKED;
            end
            CMD_READ:
                res.cell_value = shadow_cells[idx];
            default:
            begin
                if (shadow_cells[idx] == CLS_BLOCKED)
                    res.status = STS_SEED_BLOCKED;
                else if (shadow_cells[idx] == CLS_REACHED)
                    res.status = STS_SEED_REACHED;
                else
                    flood_from(item.cell_x, item.cell_y, item.cell_z);
            end
        endcase
        return res;
    endfunction

    // One command beat; valid stays up after accept until the next call or a drain
    task automatic send_cmd(input logic [1:0] cmd,
                            input logic [GFF_COORD_W-1:0] x,
                            input logic [GFF_COORD_W-1:0] y,
                            input logic [GFF_COORD_W-1:0] z,
                            input logic [1:0] cls);
        in_item_t item;
        item.command    = cmd;
        item.cell_x     = x;
        item.cell_y     = y;
        item.cell_z     = z;
        item.cell_class = cls;
        @(negedge clk);
        if (idling && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        forever
        begin
            @(posedge clk);
            if (in_ready)
                break;
        end
        awaited_results.insert(awaited_results.size(), apply_command(item));
        cmds_sent++;
        if (cmd == CMD_FILL)
            fills_sent++;
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes all three extent registers; only called while the block is idle
    task automatic set_extents(input int sx, input int sy, input int sz);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= REG_SIZE_X;
        cfg_data  <= GFF_SIZE_W'(sx);
        @(negedge clk);
        cfg_index <= REG_SIZE_Y;
        cfg_data  <= GFF_SIZE_W'(sy);
        @(negedge clk);
        cfg_index <= REG_SIZE_Z;
        cfg_data  <= GFF_SIZE_W'(sz);
        @(negedge clk);
        cfg_write <= 1'b0;
        ext_x = (sx > EDGE) ? EDGE : sx;
        ext_y = (sy > EDGE) ? EDGE : sy;
        ext_z = (sz > EDGE) ? EDGE : sz;
        settings_used++;
    endtask

    task automatic pick_cell(output logic [GFF_COORD_W-1:0] x,
                             output logic [GFF_COORD_W-1:0] y,
                             output logic [GFF_COORD_W-1:0] z);
        x = GFF_COORD_W'($urandom_range(0, ext_x - 1));
        y = GFF_COORD_W'($urandom_range(0, ext_y - 1));
        z = GFF_COORD_W'($urandom_range(0, ext_z - 1));
    endtask

    // Writes, reads, class saturation and the unused command at full extents
    task automatic test_cell_access();
        send_cmd(CMD_READ, 0, 0, 0, CLS_OPEN);
        send_cmd(CMD_WRITE, 31, 31, 31, CLS_BLOCKED);
        send_cmd(CMD_READ, 31, 31, 31, CLS_OPEN);
        send_cmd(CMD_WRITE, 1, 0, 0, 2'($urandom_range(3, 3)));
        send_cmd(CMD_READ, 1, 0, 0, CLS_OPEN);
        send_cmd(CMD_WRITE, 2, 0, 0, CLS_REACHED);
        send_cmd(CMD_READ, 2, 0, 0, CLS_OPEN);
        send_cmd(CMD_NOP, 31, 31, 31, CLS_BLOCKED);
    endtask

    // Fill from a blocked seed and from an already reached one
    task automatic test_seed_rejects();
        send_cmd(CMD_FILL, 31, 31, 31, CLS_OPEN);
        send_cmd(CMD_FILL, 2, 0, 0, CLS_OPEN);
    endtask

    // Zero extents reject every command but the NOP; coordinates at the extent are outside
    task automatic test_extent_limits();
        wait_drained();
        set_extents(0, 0, 0);
        send_cmd(CMD_READ, 0, 0, 0, CLS_OPEN);
        send_cmd(CMD_WRITE, 0, 0, 0, CLS_BLOCKED);
        send_cmd(CMD_FILL, 0, 0, 0, CLS_OPEN);
        send_cmd(CMD_NOP, 0, 0, 0, CLS_OPEN);
        wait_drained();
        set_extents(4, 5, 6);
        send_cmd(CMD_READ, 4, 0, 0, CLS_OPEN);
        send_cmd(CMD_WRITE, 0, 5, 0, CLS_BLOCKED);
        send_cmd(CMD_FILL, 0, 0, 6, CLS_OPEN);
        send_cmd(CMD_READ, 3, 4, 5, CLS_OPEN);
    endtask

    // Oversized x register is capped at the grid edge; fill runs along one line
    task automatic test_fill_line();
        wait_drained();
        set_extents(63, 1, 1);
        send_cmd(CMD_FILL, 5, 0, 0, CLS_OPEN);
        send_cmd(CMD_READ, 31, 0, 0, CLS_OPEN);
        send_cmd(CMD_READ, 0, 0, 0, CLS_OPEN);
        send_cmd(CMD_FILL, 31, 0, 0, CLS_OPEN);
    endtask

    // Full-size plane fill around the blocked cell
    task automatic test_fill_plane();
        wait_drained();
        set_extents(32, 32, 1);
        send_cmd(CMD_FILL, 0, 1, 0, CLS_OPEN);
        send_cmd(CMD_READ, 0, 0, 0, CLS_OPEN);
        send_cmd(CMD_READ, 1, 0, 0, CLS_OPEN);
    endtask

    // Random boxes, small or long and thin: reshape cells, fill from a seed, read back, some noise
    task automatic test_random_regions(input int phases, input bit with_idling);
        int                     sx;
        int                     sy;
        int                     sz;
        int                     len;
        logic [GFF_COORD_W-1:0] x;
        logic [GFF_COORD_W-1:0] y;
        logic [GFF_COORD_W-1:0] z;
        logic [1:0]             cls;
        for (int p = 0; p < phases; p++)
        begin
            wait_drained();
            idling = with_idling;
            sx = $urandom_range(1, 5);
            sy = $urandom_range(1, 5);
            sz = $urandom_range(1, 5);
            // sometimes a long thin box along one axis
            if ($urandom_range(0, 3) == 0)
            begin
                len = ($urandom_range(0, 2) == 0) ? 63 : $urandom_range(6, 32);
                sx = $urandom_range(1, 2);
                sy = $urandom_range(1, 2);
                sz = $urandom_range(1, 2);
                case ($urandom_range(0, 2))
                    0: sx = len;
                    1: sy = len;
                    default: sz = len;
                endcase
            end
            set_extents(sx, sy, sz);
            repeat ($urandom_range(2, 6))
            begin
                pick_cell(x, y, z);
                cls = ($urandom_range(0, 1) == 0) ? CLS_OPEN : 2'($urandom);
                send_cmd(CMD_WRITE, x, y, z, cls);
            end
            // usually open the seed so the fill has work to do
            pick_cell(x, y, z);
            if ($urandom_range(0, 3) != 0)
                send_cmd(CMD_WRITE, x, y, z, CLS_OPEN);
            send_cmd(CMD_FILL, x, y, z, 2'($urandom));
            repeat ($urandom_range(1, 3))
            begin
                pick_cell(x, y, z);
                send_cmd(CMD_READ, x, y, z, 2'($urandom));
            end
            if ($urandom_range(0, 2) == 0)
                send_cmd(2'($urandom), GFF_COORD_W'($urandom), GFF_COORD_W'($urandom),
                         GFF_COORD_W'($urandom), 2'($urandom));
        end
    endtask

    // Receiver side: random stall bursts while idling is on
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else if (idling && $urandom_range(0, 7) == 0)
        begin
            stall_left = $urandom_range(1, 18) - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    // Compare each result beat with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (awaited_results.size() == 0)
            begin
                $error("result beat with nothing expected: status %0d, cell_value %0d",
                       out_data.status, out_data.cell_value);
                errors++;
            end
            else
            begin
                want = awaited_results.pop_front();
                results_checked++;
                if (out_data.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, out_data.status);
                    errors++;
                end
                if (out_data.cell_value !== want.cell_value)
                begin
                    $error("cell_value: expected %0d, got %0d",
                           want.cell_value, out_data.cell_value);
                    errors++;
                end
            end
        end
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, awaited_results.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        foreach (shadow_cells[i])
            shadow_cells[i] = CLS_OPEN;
        ext_x = EDGE;
        ext_y = EDGE;
        ext_z = EDGE;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_cell_access();
        test_seed_rejects();
        test_extent_limits();
        test_fill_line();
        test_fill_plane();
        test_random_regions(6, 1'b1);
        test_random_regions(3, 1'b0);
        wait_drained();

        $display("Sent %0d commands (%0d fills) over %0d extent settings.",
                 cmds_sent, fills_sent, settings_used);
        $display("Checked %0d result beats against the shadow grid.", results_checked);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
